/* design/mad_pkg.sv */
`default_nettype none

package mad_pkg;

   // block dimensions
   localparam int CHANNELS       = 6;
   localparam int MAX_DELAY      = 4096;
   localparam int SAMPLE_BITS    = 24;

   // fixed field widths
   localparam int CH_BITS        = 3;
   localparam int DELAY_BITS     = 12;
   localparam int NUM_DELAY_REGS = 6;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 12;

   // derived widths
   localparam int CH_IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_BITS       = $clog2(MAX_DELAY);
   localparam int MAX_BITS       = $clog2(MAX_DELAY + 1);
   localparam int REM_BITS       = (DELAY_BITS > MAX_BITS) ? DELAY_BITS : MAX_BITS;
   localparam int SUM_BITS       = REM_BITS + 1;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ENABLE        = 3'd0,
      REG_CHANNEL_COUNT = 3'd1,
      REG_DELAY_CH0     = 3'd2,
      REG_DELAY_CH1     = 3'd3,
      REG_DELAY_CH2     = 3'd4,
      REG_DELAY_CH3     = 3'd5,
      REG_DELAY_CH4     = 3'd6,
      REG_DELAY_CH5     = 3'd7
   } csr_index_type;

   // input item
   typedef struct packed {
      logic [CH_BITS-1:0]            channel;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_type;

   // result item
   typedef struct packed {
      logic [CH_BITS-1:0]            channel_out;
      logic signed [SAMPLE_BITS-1:0] sample_out;
   } rsp_type;

   // settings seen by the datapath, remaining delays already reduced by the common lag
   typedef struct packed {
      logic                                     enable;
      logic [CH_BITS-1:0]                       active;
      logic [NUM_DELAY_REGS-1:0][REM_BITS-1:0]  rem;
   } cfg_type;

endpackage

`default_nettype wire

/* design/mad_lag.sv */
`default_nettype none

module mad_lag (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [mad_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [mad_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output mad_pkg::cfg_type                         cfg
);
   import mad_pkg::*;

   logic                                    enable_ff;
   logic [CH_BITS-1:0]                      count_ff;
   logic [NUM_DELAY_REGS-1:0][DELAY_BITS-1:0] delay_ff;
   cfg_type                                 cfg_ff;
   cfg_type                                 cfg_in;
   logic [CH_BITS-1:0]                      active;
   logic [DELAY_BITS-1:0]                   lag;
   logic [DELAY_BITS-1:0]                   raw;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= CH_BITS'(CHANNELS);
         delay_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_ENABLE:        enable_ff   <= csr_wdata[0];
            REG_CHANNEL_COUNT: count_ff    <= csr_wdata[CH_BITS-1:0];
            REG_DELAY_CH0:     delay_ff[0] <= csr_wdata[DELAY_BITS-1:0];
            REG_DELAY_CH1:     delay_ff[1] <= csr_wdata[DELAY_BITS-1:0];
            REG_DELAY_CH2:     delay_ff[2] <= csr_wdata[DELAY_BITS-1:0];
            REG_DELAY_CH3:     delay_ff[3] <= csr_wdata[DELAY_BITS-1:0];
            REG_DELAY_CH4:     delay_ff[4] <= csr_wdata[DELAY_BITS-1:0];
            REG_DELAY_CH5:     delay_ff[5] <= csr_wdata[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // common lag over active channels, then per-channel remaining delay
   always_comb begin
      active = (count_ff > CH_BITS'(CHANNELS)) ? CH_BITS'(CHANNELS) : count_ff;
      lag    = delay_ff[0];
      for (int k = 1; k < NUM_DELAY_REGS; k++) begin
         if ((CH_BITS'(k) < active) && (delay_ff[k] < lag)) begin
            lag = delay_ff[k];
         end
      end
      cfg_in.enable = enable_ff;
      cfg_in.active = active;
      for (int k = 0; k < NUM_DELAY_REGS; k++) begin
         raw = delay_ff[k] - lag;
         // a delay beyond the store saturates to its depth
         if (REM_BITS'(raw) > REM_BITS'(MAX_DELAY)) begin
            cfg_in.rem[k] = REM_BITS'(MAX_DELAY);
         end else begin
            cfg_in.rem[k] = REM_BITS'(raw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/mad_ring.sv */
`default_nettype none

module mad_ring (
   input  wire logic                              clock,
   input  wire logic                              we,
   input  wire logic [mad_pkg::CH_IDX_BITS-1:0]   wch,
   input  wire logic [mad_pkg::PTR_BITS-1:0]      waddr,
   input  wire logic [mad_pkg::SAMPLE_BITS-1:0]   wdata,
   input  wire logic                              re,
   input  wire logic [mad_pkg::CH_IDX_BITS-1:0]   rch,
   input  wire logic [mad_pkg::PTR_BITS-1:0]      raddr,
   output logic [mad_pkg::SAMPLE_BITS-1:0]        rdata
);
   import mad_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [CHANNELS][MAX_DELAY];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wch][waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[rch][raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/multichannel_audio_delay.sv */
`default_nettype none

// channel   ports                               carries
// req       req_valid, req_stall, req_data      channel, sample_in
// rsp       rsp_valid, rsp_stall, rsp_data      channel_out, sample_out
// csr       csr_we, csr_index, csr_wdata        register writes, no read-back
//
// one item per cycle sustained while rsp is not stalled; an item is registered in the
// issue stage, then in the result stage beside the registered read of the sample memory.
// reset clears positions and fill marks; entries not yet written read as zero,
// so no clearing pass runs and items are taken right after reset.
// a stall at rsp holds both stages; req_stall rises while the issue stage is
// full and its item cannot move on to the result stage.

module multichannel_audio_delay (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire mad_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mad_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [mad_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [mad_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mad_pkg::*;

   cfg_type                       cfg;

   // issue stage
   logic                          s1_valid_ff;
   req_type                       s1_item_ff;

   // result stage
   logic                          s2_valid_ff;
   logic [CH_BITS-1:0]            s2_ch_ff;
   logic [SAMPLE_BITS-1:0]        s2_sample_ff;
   logic                          s2_ring_ff;
   logic                          s2_zero_ff;

   // per-channel write positions and wrap marks
   logic [PTR_BITS-1:0]           wp_ff [CHANNELS];
   logic [CHANNELS-1:0]           wrap_ff;
   logic [PTR_BITS-1:0]           wp_in;

   logic [CH_IDX_BITS-1:0]        ci;
   logic                          active_ch;
   logic [REM_BITS-1:0]           d;
   logic [PTR_BITS-1:0]           wp;
   logic [SUM_BITS-1:0]           sum;
   logic [PTR_BITS-1:0]           rd;
   logic                          held;
   logic                          do_ring;
   logic                          issue;
   logic                          take;
   logic [SAMPLE_BITS-1:0]        rdata;

   mad_lag u_lag (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // address and path selection for the item in the issue stage
   always_comb begin
      ci        = s1_item_ff.channel[CH_IDX_BITS-1:0];
      active_ch = cfg.enable && (s1_item_ff.channel < cfg.active);
      d         = active_ch ? cfg.rem[s1_item_ff.channel] : '0;
      wp        = active_ch ? wp_ff[ci] : '0;
      sum       = SUM_BITS'(wp) + SUM_BITS'(MAX_DELAY) - SUM_BITS'(d);
      if (sum >= SUM_BITS'(MAX_DELAY)) begin
         rd = PTR_BITS'(sum - SUM_BITS'(MAX_DELAY));
      end else begin
         rd = PTR_BITS'(sum);
      end
      // the entry holds a sample once the channel has written past it
      held      = (active_ch && wrap_ff[ci]) || (SUM_BITS'(d) <= SUM_BITS'(wp));
      do_ring   = active_ch && (d != '0);
      if (wp == PTR_BITS'(MAX_DELAY - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp + PTR_BITS'(1);
      end
   end

   // handshake
   assign issue     = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !issue;
   assign take      = req_valid && !req_stall;

   mad_ring u_ring (
      .clock (clock),
      .we    (issue && do_ring),
      .wch   (ci),
      .waddr (wp),
      .wdata (SAMPLE_BITS'(s1_item_ff.sample_in)),
      .re    (issue && do_ring),
      .rch   (ci),
      .raddr (rd),
      .rdata (rdata)
   );

   // issue stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (issue) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= req_data;
      end
   end

   // write position advance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            wp_ff[k] <= '0;
         end
         wrap_ff <= '0;
      end else if (issue && do_ring) begin
         wp_ff[ci] <= wp_in;
         if (wp == PTR_BITS'(MAX_DELAY - 1)) begin
            wrap_ff[ci] <= 1'b1;
         end
      end
   end

   // result stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (issue) begin
         s2_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_ch_ff     <= s1_item_ff.channel;
         s2_sample_ff <= SAMPLE_BITS'(s1_item_ff.sample_in);
         s2_ring_ff   <= do_ring && held;
         s2_zero_ff   <= do_ring && !held;
      end
   end

   // delayed sample or the item's own sample; an unwritten entry reads zero
   always_comb begin
      rsp_data.channel_out = s2_ch_ff;
      if (s2_ring_ff) begin
         rsp_data.sample_out = rdata;
      end else if (s2_zero_ff) begin
         rsp_data.sample_out = '0;
      end else begin
         rsp_data.sample_out = s2_sample_ff;
      end
   end

   assign rsp_valid = s2_valid_ff;

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mad_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT   = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1900;
   localparam int TAIL_START   = 1700;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // settings as the block should hold them
   logic                     cfg_enable;
   logic [CH_BITS-1:0]       cfg_count;
   logic [DELAY_BITS-1:0]    cfg_delay [NUM_DELAY_REGS];
   logic [DELAY_BITS-1:0]    plan_delays [NUM_DELAY_REGS];

   // per-channel sample history
   logic [SAMPLE_BITS-1:0]   held_samples [CHANNELS][MAX_DELAY];
   int                       write_ptr [CHANNELS];

   req_type                  sample_backlog [$];
   rsp_type                  due_outputs [$];

   int                       mismatch_count = 0;
   int                       gap_percent = 0;
   int                       stall_percent = 0;
   bit                       quiet_tail = 1'b0;
   int                       gap_left = 0;
   int                       hold_left = 0;
   int                       idle_cycles = 0;

   multichannel_audio_delay u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one sample through the delay line: returns the delayed sample, updates history
   function automatic rsp_type delay_line_step(req_type item);
      rsp_type result;
      int      active;
      int      lag;
      int      remaining;
      int      rd_ptr;
      int      ch;
      ch = item.channel;
      active = (cfg_count > CHANNELS) ? CHANNELS : cfg_count;
      result.channel_out = item.channel;
      result.sample_out  = item.sample_in;
      if (cfg_enable && ch < active) begin
         // common lag over the active channels
         lag = cfg_delay[0];
         for (int k = 1; k < active; k++) begin
            if (cfg_delay[k] < lag) lag = cfg_delay[k];
         end
         remaining = cfg_delay[ch] - lag;
         if (remaining > MAX_DELAY) remaining = MAX_DELAY;
         if (remaining != 0) begin
            rd_ptr = (write_ptr[ch] + MAX_DELAY - remaining) % MAX_DELAY;
            result.sample_out = held_samples[ch][rd_ptr];
            held_samples[ch][write_ptr[ch]] = item.sample_in;
            write_ptr[ch] = (write_ptr[ch] + 1) % MAX_DELAY;
         end
      end
      return result;
   endfunction

   // driver: feeds items from the backlog, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) due_outputs.push_back(delay_line_step(req_data));
         if (!(req_valid && req_stall)) begin
            if (gap_left == 0 && !quiet_tail && sample_backlog.size() > 0 &&
                $urandom_range(99, 0) < gap_percent)
               gap_left = $urandom_range(19, 1);
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (sample_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= sample_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result item against the oldest expectation, random stalls
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_outputs.size() == 0) begin
               $error("unexpected item: channel_out %0d sample_out %0d",
                      rsp_data.channel_out, rsp_data.sample_out);
               mismatch_count++;
            end else begin
               want = due_outputs.pop_front();
               if (rsp_data.channel_out !== want.channel_out) begin
                  $error("channel_out mismatch: expected %0d, actual %0d",
                         want.channel_out, rsp_data.channel_out);
                  mismatch_count++;
               end
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want.sample_out, rsp_data.sample_out);
                  mismatch_count++;
               end
            end
         end
         if (hold_left == 0 && !quiet_tail && $urandom_range(99, 0) < stall_percent)
            hold_left = $urandom_range(19, 1);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_ENABLE:        cfg_enable = value[0];
         REG_CHANNEL_COUNT: cfg_count  = value[CH_BITS-1:0];
         default:           cfg_delay[idx - REG_DELAY_CH0] = value[DELAY_BITS-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic en, logic [CH_BITS-1:0] count);
      write_register(REG_ENABLE, CSR_DATA_BITS'(en));
      write_register(REG_CHANNEL_COUNT, CSR_DATA_BITS'(count));
      for (int k = 0; k < NUM_DELAY_REGS; k++)
         write_register(csr_index_type'(REG_DELAY_CH0 + k), plan_delays[k]);
   endtask

   task automatic queue_sample(int ch, logic [SAMPLE_BITS-1:0] sample);
      req_type item;
      item.channel   = CH_BITS'(ch);
      item.sample_in = sample;
      sample_backlog.push_back(item);
   endtask

   // wait until every item is accepted and every result has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || due_outputs.size() != 0);
   endtask

   initial begin
      logic [CH_BITS-1:0]     count;
      logic                   en;
      logic [SAMPLE_BITS-1:0] sample;
      int                     issued;
      int                     phase;
      int                     batch;
      int                     base;
      int                     spread;
      int                     ch;
      int                     pick;

      // reset state of the predictor
      cfg_enable = 1'b0;
      cfg_count  = CH_BITS'(CHANNELS);
      for (int k = 0; k < NUM_DELAY_REGS; k++) cfg_delay[k] = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         write_ptr[c] = 0;
         for (int a = 0; a < MAX_DELAY; a++) held_samples[c][a] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: pass through
      queue_sample(0, 24'h7fffff);
      queue_sample(5, 24'h800000);
      wait_drained();

      // enabled, no common lag; zero and full-range remaining delays
      plan_delays = '{12'd0, 12'd3, 12'd1, 12'd2, 12'd4095, 12'd0};
      apply_settings(1'b1, 3'd6);
      queue_sample(1, 24'h7fffff);
      queue_sample(1, 24'h800000);
      queue_sample(1, 24'h000000);
      queue_sample(1, 24'hffffff);
      queue_sample(2, 24'h123456);
      queue_sample(2, 24'h654321);
      queue_sample(4, 24'h555555);
      queue_sample(0, 24'haaaaaa);
      queue_sample(6, 24'h0f0f0f);
      queue_sample(7, 24'hf0f0f0);
      wait_drained();

      // fewer active channels; held samples survive the settings change
      apply_settings(1'b1, 3'd2);
      queue_sample(1, 24'h111111);
      queue_sample(3, 24'h333333);
      queue_sample(5, 24'h777777);
      wait_drained();

      // no active channel at all
      apply_settings(1'b1, 3'd0);
      queue_sample(0, 24'h222222);
      queue_sample(1, 24'h444444);
      wait_drained();

      // count above the channel total, nonzero common lag
      plan_delays = '{12'd5, 12'd7, 12'd5, 12'd9, 12'd6, 12'd8};
      apply_settings(1'b1, 3'd7);
      queue_sample(0, 24'h7fffff);
      queue_sample(1, 24'h800000);
      queue_sample(3, 24'h010203);
      queue_sample(4, 24'h040506);
      queue_sample(5, 24'h070809);
      queue_sample(1, 24'h0a0b0c);
      wait_drained();

      // random phases
      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         phase++;
         case (phase)
            1: begin
               for (int k = 0; k < NUM_DELAY_REGS; k++) plan_delays[k] = 12'd4095;
               en    = 1'b1;
               count = 3'd6;
            end
            2: begin
               for (int k = 0; k < NUM_DELAY_REGS; k++)
                  plan_delays[k] = (k % 2 == 0) ? 12'd0 : 12'd4095;
               en    = 1'b1;
               count = 3'd6;
            end
            default: begin
               spread = ($urandom_range(3, 0) == 0) ? 200 : 12;
               base   = ($urandom_range(2, 0) == 0) ? $urandom_range(4095 - spread, 0) : 0;
               for (int k = 0; k < NUM_DELAY_REGS; k++)
                  plan_delays[k] = DELAY_BITS'(base + $urandom_range(spread, 0));
               en   = ($urandom_range(9, 0) != 0);
               pick = $urandom_range(19, 0);
               if (pick < 16)       count = CH_BITS'($urandom_range(CHANNELS, 1));
               else if (pick < 18)  count = CH_BITS'(CHANNELS);
               else if (pick == 18) count = 3'd0;
               else                 count = 3'd7;
            end
         endcase
         apply_settings(en, count);

         // idling mix for this phase; none in the tail
         case ($urandom_range(2, 0))
            0:       gap_percent = 0;
            1:       gap_percent = 4;
            default: gap_percent = 25;
         endcase
         case ($urandom_range(2, 0))
            0:       stall_percent = 0;
            1:       stall_percent = 4;
            default: stall_percent = 25;
         endcase
         if (issued >= TAIL_START) quiet_tail = 1'b1;

         batch = $urandom_range(160, 40);
         for (int n = 0; n < batch; n++) begin
            // mostly active channels so history is read back
            if (count >= 1 && count <= CHANNELS && $urandom_range(9, 0) != 0)
               ch = $urandom_range(count - 1, 0);
            else
               ch = $urandom_range(7, 0);
            case ($urandom_range(15, 0))
               0:       sample = 24'h7fffff;
               1:       sample = 24'h800000;
               default: sample = SAMPLE_BITS'($urandom());
            endcase
            queue_sample(ch, sample);
         end
         issued += batch;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* multichannel_audio_delay.f */
design/mad_pkg.sv
design/mad_lag.sv
design/mad_ring.sv
design/multichannel_audio_delay.sv
dv/testbench.sv
